@@ src/grsc_pkg.sv @@
// ---------------------------------------------------------------------------
// grsc_pkg
// Shared widths, constants and controller/datapath interface types for the
// gain ramp and soft clipper.
// ---------------------------------------------------------------------------
package grsc_pkg;

  localparam int MAX_LANES_DEF = 8;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 20;
  localparam int CC_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int P_W    = PROD_W - 16;
  localparam int MAG_W  = P_W - 1;
  localparam int REM_W  = MAG_W + 2;
  localparam int QUO_W  = 21;

  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [GAIN_W-1:0]   UNITY_GAIN     = 20'd65536;
  localparam logic [GAIN_W-1:0]   RAMP_STEP_RST  = 20'd64;
  localparam logic [CC_W-1:0]     CHANNELS_RST   = 4'd2;
  localparam logic [SAMPLE_W-1:0] KNEE_Q23       = 24'd6291456;
  localparam logic [SAMPLE_W-1:0] Q23_MAX        = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] Q23_MIN        = 24'h800000;
  localparam logic [PROD_W-1:0]   ROUND_HALF     = 45'd32768;
  localparam logic [REM_W-1:0]    FULL_SCALE     = 30'd8388608;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_step;
    logic out_load;
  } grsc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic boost;
  } grsc_status_t;

endpackage

@@ src/gain_ramp_soft_clip.sv @@
// ---------------------------------------------------------------------------
// gain_ramp_soft_clip
// Frame gain with a per-frame ramp toward a target, a soft clipper above
// unity gain and saturation otherwise.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata: sample_0..sample_7
//   out_     out  out_tvalid/out_tready out_tdata: out_0..out_7
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// After acceptance the frame is multiplied lane by lane, the per-lane fold
// divider runs when the gain is above unity, and the output register then
// loads; the next frame is taken only after that load, so the block does not
// accept a new frame before the last one is handed over. One shared
// multiplier serves all lanes.
// Reset is synchronous, active low; the gain starts at zero and jumps to the
// target on the first frame. A stalled output holds its transaction while the
// next frame is processed; that frame then waits for the output register and
// the input stays stalled until it is handed over.
// ---------------------------------------------------------------------------
module gain_ramp_soft_clip #(
  parameter int MAX_LANES = grsc_pkg::MAX_LANES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // sample_0 .. sample_7, 24 bits each, lowest bits first
  input  logic [MAX_LANES*grsc_pkg::SAMPLE_W-1:0]  in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // out_0 .. out_7, 24 bits each, lowest bits first
  output logic [MAX_LANES*grsc_pkg::SAMPLE_W-1:0]  out_tdata,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [grsc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [grsc_pkg::GAIN_W-1:0]              cfg_data
);

  localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

  grsc_pkg::grsc_cmd_t    cmd;
  grsc_pkg::grsc_status_t st;
  logic [LANE_W-1:0]      mul_idx;

  assign cfg_ready = 1'b1;

  grsc_ctrl #(
    .MAX_LANES (MAX_LANES),
    .LANE_W    (LANE_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd),
    .mul_idx   (mul_idx)
  );

  grsc_datapath #(
    .MAX_LANES (MAX_LANES),
    .LANE_W    (LANE_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .mul_idx    (mul_idx),
    .st         (st),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/grsc_lane.sv @@
// ---------------------------------------------------------------------------
// grsc_lane
// One output lane: takes the rounded product, saturates it or sets up the
// soft-clip fold, and runs the fold's restoring divider one bit per step.
// ---------------------------------------------------------------------------
module grsc_lane (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic                                  active,
  input  logic                                  boost,
  input  logic                                  step,
  input  logic signed [grsc_pkg::P_W-1:0]       p,
  output logic        [grsc_pkg::SAMPLE_W-1:0]  res
);

  logic                              neg;
  logic [grsc_pkg::P_W-1:0]          m_full;
  logic [grsc_pkg::MAG_W-1:0]        m;
  logic                              over_knee;
  logic [grsc_pkg::MAG_W-1:0]        d;
  logic [grsc_pkg::REM_W-1:0]        d4;
  logic [grsc_pkg::SAMPLE_W-1:0]     sat;
  logic [grsc_pkg::REM_W:0]          rem2;
  logic [grsc_pkg::SAMPLE_W-1:0]     fold_mag;

  logic                              clip_r;
  logic                              neg_r;
  logic [grsc_pkg::REM_W-1:0]        rem_r;
  logic [grsc_pkg::REM_W-1:0]        den_r;
  logic [grsc_pkg::QUO_W-1:0]        quo_r;
  logic [grsc_pkg::SAMPLE_W-1:0]     res_r;

  always_comb begin
    neg       = p[grsc_pkg::P_W-1];
    m_full    = neg ? (~p + 1'b1) : p;
    m         = m_full[grsc_pkg::MAG_W-1:0];
    over_knee = m > grsc_pkg::MAG_W'(grsc_pkg::KNEE_Q23);
    d         = m - grsc_pkg::MAG_W'(grsc_pkg::KNEE_Q23);
    d4        = {d, 2'b00};
    if (p > grsc_pkg::P_W'(signed'(grsc_pkg::Q23_MAX))) begin
      sat = grsc_pkg::Q23_MAX;
    end else if (p < signed'(grsc_pkg::P_W'(signed'(grsc_pkg::Q23_MIN)))) begin
      sat = grsc_pkg::Q23_MIN;
    end else begin
      sat = p[grsc_pkg::SAMPLE_W-1:0];
    end
    rem2     = {rem_r, 1'b0};
    fold_mag = grsc_pkg::KNEE_Q23 + grsc_pkg::SAMPLE_W'(quo_r);
    res      = clip_r ? (neg_r ? (~fold_mag + 1'b1) : fold_mag) : res_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      clip_r <= active & boost & over_knee;
      neg_r  <= neg;
      rem_r  <= d4;
      den_r  <= d4 + grsc_pkg::FULL_SCALE;
      quo_r  <= '0;
      if (!active) begin
        res_r <= '0;
      end else if (boost) begin
        res_r <= p[grsc_pkg::SAMPLE_W-1:0];
      end else begin
        res_r <= sat;
      end
    end else if (step && clip_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= grsc_pkg::REM_W'(rem2 - {1'b0, den_r});
        quo_r <= {quo_r[grsc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2[grsc_pkg::REM_W-1:0];
        quo_r <= {quo_r[grsc_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/grsc_datapath.sv @@
// ---------------------------------------------------------------------------
// grsc_datapath
// Configuration registers, gain ramp, frame buffer, shared multiplier,
// lane array and output register.
// ---------------------------------------------------------------------------
module grsc_datapath #(
  parameter int MAX_LANES = grsc_pkg::MAX_LANES_DEF,
  parameter int LANE_W    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  grsc_pkg::grsc_cmd_t                         cmd,
  input  logic [LANE_W-1:0]                           mul_idx,
  output grsc_pkg::grsc_status_t                      st,
  input  logic [MAX_LANES*grsc_pkg::SAMPLE_W-1:0]     in_tdata,
  input  logic                                        cfg_valid,
  input  logic [grsc_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [grsc_pkg::GAIN_W-1:0]                 cfg_data,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [MAX_LANES*grsc_pkg::SAMPLE_W-1:0]     out_tdata
);

  logic [grsc_pkg::GAIN_W-1:0]   target_r;
  logic [grsc_pkg::GAIN_W-1:0]   step_r;
  logic [grsc_pkg::CC_W-1:0]     cc_r;
  logic [grsc_pkg::GAIN_W-1:0]   gain_r;
  logic [grsc_pkg::GAIN_W-1:0]   gain_nxt;
  logic                          started_r;
  logic [grsc_pkg::GAIN_W:0]     gain_sum;
  logic [grsc_pkg::GAIN_W-1:0]   gain_diff;

  logic [grsc_pkg::SAMPLE_W-1:0] samp_r [MAX_LANES];
  logic signed [grsc_pkg::PROD_W-1:0] prod_r;
  logic signed [grsc_pkg::PROD_W-1:0] prod_rnd;
  logic                          post_en_r;
  logic [LANE_W-1:0]             post_idx_r;
  logic                          boost_r;

  logic [grsc_pkg::SAMPLE_W-1:0] lane_res [MAX_LANES];
  logic [grsc_pkg::SAMPLE_W-1:0] out_r    [MAX_LANES];
  logic                          out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= grsc_pkg::UNITY_GAIN;
      step_r   <= grsc_pkg::RAMP_STEP_RST;
      cc_r     <= grsc_pkg::CHANNELS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        grsc_pkg::REG_TARGET_GAIN:   target_r <= cfg_data;
        grsc_pkg::REG_RAMP_STEP:     step_r   <= cfg_data;
        grsc_pkg::REG_CHANNEL_COUNT: cc_r     <= cfg_data[grsc_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gain_sum  = {1'b0, gain_r} + {1'b0, step_r};
    gain_diff = gain_r - target_r;
    gain_nxt  = gain_r;
    if (!started_r) begin
      gain_nxt = target_r;
    end else if (gain_r < target_r) begin
      gain_nxt = (gain_sum > {1'b0, target_r}) ? target_r : gain_sum[grsc_pkg::GAIN_W-1:0];
    end else if (gain_r > target_r) begin
      gain_nxt = (step_r > gain_diff) ? target_r : (gain_r - step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= '0;
      started_r <= 1'b0;
      boost_r   <= 1'b0;
    end else if (cmd.load) begin
      gain_r    <= gain_nxt;
      started_r <= 1'b1;
      boost_r   <= gain_nxt > grsc_pkg::UNITY_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < MAX_LANES; j++) begin
        samp_r[j] <= in_tdata[j*grsc_pkg::SAMPLE_W +: grsc_pkg::SAMPLE_W];
      end
    end
    if (cmd.mul_en) begin
      prod_r     <= $signed(samp_r[mul_idx]) * $signed({1'b0, gain_r});
      post_idx_r <= mul_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_en_r <= 1'b0;
    end else begin
      post_en_r <= cmd.mul_en;
    end
  end

  assign prod_rnd = prod_r + signed'(grsc_pkg::ROUND_HALF);

  for (genvar j = 0; j < MAX_LANES; j++) begin : g_lane
    grsc_lane u_lane (
      .clk    (clk),
      .load   (post_en_r && (post_idx_r == LANE_W'(j))),
      .active ((grsc_pkg::CC_W)'(j) < cc_r),
      .boost  (boost_r),
      .step   (cmd.div_step),
      .p      (prod_rnd[grsc_pkg::PROD_W-1:16]),
      .res    (lane_res[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int j = 0; j < MAX_LANES; j++) begin
        out_r[j] <= lane_res[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_LANES; j++) begin
      out_tdata[j*grsc_pkg::SAMPLE_W +: grsc_pkg::SAMPLE_W] = out_r[j];
    end
  end

  assign out_tvalid  = out_valid_r;
  assign st.out_free = !out_valid_r || out_tready;
  assign st.boost    = boost_r;

`ifndef ASSERT_OFF
  a_gain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |=> $stable(gain_r))
    else $error("gain changed without a frame");

  a_ramp_up_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && started_r && (gain_r < target_r)) |=>
      (gain_r <= $past(target_r)) && (gain_r >= $past(gain_r)))
    else $error("upward ramp overshot the target");

  a_ramp_down_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && started_r && (gain_r > target_r)) |=>
      (gain_r >= $past(target_r)) && (gain_r <= $past(gain_r)))
    else $error("downward ramp overshot the target");
`endif

endmodule

@@ src/grsc_ctrl.sv @@
// ---------------------------------------------------------------------------
// grsc_ctrl
// Frame sequencer: accept, multiply lane by lane, run the fold divider when
// the gain is above unity, then hand the frame to the output register.
// ---------------------------------------------------------------------------
module grsc_ctrl #(
  parameter int MAX_LANES = grsc_pkg::MAX_LANES_DEF,
  parameter int LANE_W    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  grsc_pkg::grsc_status_t  st,
  output grsc_pkg::grsc_cmd_t     cmd,
  output logic [LANE_W-1:0]       mul_idx
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(MAX_LANES - 1);
  localparam logic [grsc_pkg::DIV_CNT_W-1:0] LAST_STEP =
    grsc_pkg::DIV_CNT_W'(grsc_pkg::DIV_STEPS - 1);

  logic [2:0]                        state_r, state_nxt;
  logic [LANE_W-1:0]                 idx_r, idx_nxt;
  logic [grsc_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == LAST_LANE) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_nxt   = '0;
        state_nxt = st.boost ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign mul_idx   = idx_r;

`ifndef ASSERT_OFF
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("output register overwritten");

  a_load_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cmd.mul_en && (mul_idx == '0)))
    else $error("frame accepted without starting multiplication");
`endif

endmodule

@@ tb/gain_ramp_soft_clip_checker.sv @@
// ---------------------------------------------------------------------------
// gain_ramp_soft_clip_checker
// Watches the config, input and output channels of the gain ramp and soft
// clipper. It keeps its own copy of the registers and the ramp state, and
// computes the expected output frame for every accepted input frame. Each
// accepted output frame is compared lane by lane with the oldest prediction.
// ---------------------------------------------------------------------------
module gain_ramp_soft_clip_checker
  import grsc_pkg::*;
#(
  parameter int LANES = MAX_LANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [LANES*SAMPLE_W-1:0]   in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [LANES*SAMPLE_W-1:0]   out_tdata,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [GAIN_W-1:0]           cfg_data,
  output int                          fail_count,
  output int                          pending
);

  localparam int FRAME_W = LANES * SAMPLE_W;
  localparam longint KNEE = KNEE_Q23;
  localparam longint FULL = longint'(1) << 23;
  localparam longint POS_LIMIT = 8388607;
  localparam longint NEG_LIMIT = -8388608;

  logic [GAIN_W-1:0] target_gain;
  logic [GAIN_W-1:0] ramp_step;
  logic [CC_W-1:0]   channel_count;
  logic [GAIN_W-1:0] current_gain;
  logic              gain_primed;

  logic [FRAME_W-1:0] expected_frames[$];

  function automatic logic [FRAME_W-1:0] scale_frame(logic [FRAME_W-1:0] frame);
    logic [GAIN_W:0]    sum;
    logic [FRAME_W-1:0] res;
    longint             gain;
    longint             s;
    longint             p;
    longint             m;
    longint             d;
    longint             mag;
    int                 lanes;
    if (!gain_primed) begin
      gain_primed = 1'b1;
      current_gain = target_gain;
    end else if (current_gain < target_gain) begin
      sum = {1'b0, current_gain} + {1'b0, ramp_step};
      current_gain = (sum > {1'b0, target_gain}) ? target_gain : sum[GAIN_W-1:0];
    end else if (current_gain > target_gain) begin
      if (ramp_step > current_gain - target_gain) current_gain = target_gain;
      else current_gain = current_gain - ramp_step;
    end
    gain = current_gain;
    lanes = (channel_count > LANES) ? LANES : int'(channel_count);
    res = '0;
    for (int j = 0; j < LANES; j++) begin
      if (j < lanes) begin
        s = $signed(frame[j*SAMPLE_W +: SAMPLE_W]);
        p = (s * gain + 32768) >>> 16;
        if (current_gain > UNITY_GAIN) begin
          m = (p < 0) ? -p : p;
          if (m > KNEE) begin
            d = m - KNEE;
            mag = KNEE + (d * FULL) / (FULL + 4 * d);
            p = (p < 0) ? -mag : mag;
          end
        end else begin
          if (p > POS_LIMIT) p = POS_LIMIT;
          else if (p < NEG_LIMIT) p = NEG_LIMIT;
        end
        res[j*SAMPLE_W +: SAMPLE_W] = p[SAMPLE_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [FRAME_W-1:0] want;
    if (!rst_n) begin
      target_gain   = UNITY_GAIN;
      ramp_step     = RAMP_STEP_RST;
      channel_count = CHANNELS_RST;
      current_gain  = '0;
      gain_primed   = 1'b0;
      fail_count    = 0;
      expected_frames.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_GAIN:   target_gain   = cfg_data;
          REG_RAMP_STEP:     ramp_step     = cfg_data;
          REG_CHANNEL_COUNT: channel_count = cfg_data[CC_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          $error("out_tdata: expected no transaction, actual %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          for (int j = 0; j < LANES; j++) begin
            if (out_tdata[j*SAMPLE_W +: SAMPLE_W] !== want[j*SAMPLE_W +: SAMPLE_W]) begin
              $error("out_%0d: expected %0d, actual %0d", j,
                     $signed(want[j*SAMPLE_W +: SAMPLE_W]),
                     $signed(out_tdata[j*SAMPLE_W +: SAMPLE_W]));
              fail_count++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) expected_frames.push_back(scale_frame(in_tdata));
      pending <= expected_frames.size();
    end
  end

endmodule

@@ tb/gain_ramp_soft_clip_test.sv @@
// ---------------------------------------------------------------------------
// gain_ramp_soft_clip_test
// Stimulus for the gain ramp and soft clipper: a directed pass over sample
// extremes, the knee, zero and oversized channel counts, a stuck ramp and a
// retargeted ramp, then randomly configured phases of random frames with
// bursty idling on both channels. The checker predicts and compares.
// ---------------------------------------------------------------------------
module gain_ramp_soft_clip_test;
  import grsc_pkg::*;

  localparam int LANES = MAX_LANES_DEF;
  localparam int FRAME_W = LANES * SAMPLE_W;
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_FRAMES = 750;
  localparam int QUIET_AFTER = 620;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic [FRAME_W-1:0] in_tdata = '0;
  logic               out_tready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET_GAIN;
  logic [GAIN_W-1:0]  cfg_data = '0;
  wire                in_tready;
  wire                out_tvalid;
  wire [FRAME_W-1:0]  out_tdata;
  wire                cfg_ready;

  int mismatches;
  int outstanding;
  bit quiet = 1'b0;
  int gap_pct = 0;
  int frames_sent = 0;
  int settings = 0;
  int idle_cycles = 0;
  int rdy_cnt = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gain_ramp_soft_clip u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gain_ramp_soft_clip_checker #(.LANES(LANES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (mismatches),
    .pending    (outstanding)
  );

  // receiver: alternate ready runs and stall bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (rdy_cnt > 1) begin
      rdy_cnt <= rdy_cnt - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      rdy_cnt <= $urandom_range(1, 10);
    end else begin
      out_tready <= 1'b1;
      rdy_cnt <= $urandom_range(1, 30);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("gain_ramp_soft_clip verification failed");
        $finish;
      end
    end
  end

  function automatic logic [FRAME_W-1:0] fill(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
    return {b, a, b, a, b, a, b, a};
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] r;
    case ($urandom_range(0, 11))
      0: r = Q23_MAX;
      1: r = Q23_MIN;
      2: r = '0;
      3: r = '1;
      4: r = SAMPLE_W'($urandom_range(0, 1023));
      5: r = ~SAMPLE_W'($urandom_range(0, 1023));
      6: r = SAMPLE_W'($urandom_range(393000, 394000));
      7: r = SAMPLE_W'($urandom_range(6291000, 6292000));
      8: r = ~SAMPLE_W'($urandom_range(6291000, 6292000));
      default: r = SAMPLE_W'($urandom());
    endcase
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] rand_frame();
    logic [FRAME_W-1:0] f;
    for (int j = 0; j < LANES; j++) f[j*SAMPLE_W +: SAMPLE_W] = rand_sample();
    return f;
  endfunction

  task automatic send_frame(input logic [FRAME_W-1:0] frame);
    in_tdata <= frame;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    frames_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // hold the sender until every frame has come back, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    settings++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    int random_sent;
    int phase_len;
    logic [GAIN_W-1:0] tgt;
    logic [GAIN_W-1:0] stp;
    logic [GAIN_W-1:0] cc;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 30;

    // reset settings: jump to unity, two lanes
    send_frame(fill(Q23_MAX, Q23_MIN));
    send_frame(fill(Q23_MIN, Q23_MAX));
    send_frame(fill('0, '1));
    send_frame(fill(24'd1, 24'h555555));

    // full gain and step, all lanes, write to the unused index
    settle();
    write_reg(REG_TARGET_GAIN, 20'hFFFFF);
    write_reg(REG_RAMP_STEP, 20'hFFFFF);
    write_reg(REG_CHANNEL_COUNT, 20'd8);
    write_reg(REG_SPARE, 20'hFFFFF);
    cfg_valid <= 1'b0;
    send_frame(fill(Q23_MAX, Q23_MIN));
    send_frame({-24'sd1, 24'd0, -24'sd393217, -24'sd393216, -24'sd393215,
                24'd393215, 24'd393216, 24'd393217});
    send_frame(fill(24'hAAAAAA, 24'h555555));
    send_frame({-24'sd65536, 24'd65536, -24'sd100, 24'd100, -24'sd1, 24'd1,
                -24'sd524288, 24'd524288});

    // just above unity, channel count beyond the lane count
    settle();
    write_reg(REG_TARGET_GAIN, 20'd65537);
    write_reg(REG_CHANNEL_COUNT, 20'd15);
    cfg_valid <= 1'b0;
    send_frame({-24'sd6291457, 24'd6291455, Q23_MIN, Q23_MAX, -24'sd6291360,
                24'd6291360, -24'sd6291456, 24'd6291456});
    send_frame(fill(Q23_MAX, Q23_MIN));

    // zero step while off target: gain stays
    settle();
    write_reg(REG_TARGET_GAIN, UNITY_GAIN);
    write_reg(REG_RAMP_STEP, 20'd0);
    cfg_valid <= 1'b0;
    send_frame(fill(Q23_MAX, Q23_MIN));
    send_frame(fill(Q23_MIN, Q23_MAX));

    // ramp down to zero with no active lanes, then with three
    settle();
    write_reg(REG_TARGET_GAIN, 20'd0);
    write_reg(REG_RAMP_STEP, 20'd30000);
    write_reg(REG_CHANNEL_COUNT, 20'd0);
    cfg_valid <= 1'b0;
    repeat (3) send_frame(fill(Q23_MAX, Q23_MIN));
    settle();
    write_reg(REG_CHANNEL_COUNT, 20'hFFF03);
    cfg_valid <= 1'b0;
    send_frame(fill(Q23_MAX, Q23_MIN));

    // ramp up, then retarget mid-ramp
    settle();
    write_reg(REG_TARGET_GAIN, 20'd200000);
    write_reg(REG_RAMP_STEP, 20'd50000);
    write_reg(REG_CHANNEL_COUNT, 20'd1);
    cfg_valid <= 1'b0;
    send_frame(fill(Q23_MAX, Q23_MIN));
    send_frame(fill(Q23_MIN, Q23_MAX));
    settle();
    write_reg(REG_TARGET_GAIN, 20'd60000);
    cfg_valid <= 1'b0;
    repeat (3) send_frame(rand_frame());

    random_sent = 0;
    while (random_sent < RANDOM_FRAMES) begin
      settle();
      case ($urandom_range(0, 7))
        0: tgt = '0;
        1: tgt = UNITY_GAIN;
        2: tgt = UNITY_GAIN - 20'd1;
        3: tgt = UNITY_GAIN + 20'd1;
        4: tgt = 20'hFFFFF;
        5: tgt = GAIN_W'($urandom_range(65536, 200000));
        default: tgt = GAIN_W'($urandom());
      endcase
      case ($urandom_range(0, 7))
        0: stp = '0;
        1: stp = 20'd1;
        2: stp = 20'hFFFFF;
        3, 4: stp = GAIN_W'($urandom_range(1, 4096));
        default: stp = GAIN_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0: cc = '0;
        1: cc = GAIN_W'($urandom_range(9, 15));
        default: cc = GAIN_W'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 3) == 0) cc[GAIN_W-1:CC_W] = (GAIN_W-CC_W)'($urandom());
      if ($urandom_range(0, 2) != 0) write_reg(REG_TARGET_GAIN, tgt);
      if ($urandom_range(0, 2) != 0) write_reg(REG_RAMP_STEP, stp);
      if ($urandom_range(0, 2) != 0) write_reg(REG_CHANNEL_COUNT, cc);
      cfg_valid <= 1'b0;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      quiet = (random_sent >= QUIET_AFTER);
      phase_len = quiet ? (RANDOM_FRAMES - random_sent) : int'($urandom_range(30, 70));
      repeat (phase_len) send_frame(rand_frame());
      random_sent += phase_len;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d frames over %0d register settings; ramps up, down and stuck,",
             frames_sent, settings);
    $display("Summary: soft clip and saturation paths, channel counts from 0 to 15");
    if (mismatches == 0 && outstanding == 0) begin
      $display("gain_ramp_soft_clip verification clean");
    end else begin
      $display("gain_ramp_soft_clip verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/grsc_pkg.sv
src/grsc_lane.sv
src/grsc_datapath.sv
src/grsc_ctrl.sv
src/gain_ramp_soft_clip.sv
tb/gain_ramp_soft_clip_checker.sv
tb/gain_ramp_soft_clip_test.sv
